// ----- rtl/plf_pkg.sv -----
// ----------------------------------------------------------------------------
// plf_pkg
// Shared types, codes and constants of the presence LED fader.
// ----------------------------------------------------------------------------
package plf_pkg;

    localparam int LEVEL_W = 8;
    localparam int TIMER_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
    localparam logic [TIMER_W-1:0] DETECT_WINDOW_TICKS = 16'd1000;
    localparam logic [TIMER_W-1:0] TIMER_SAT = 16'hFFFF;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_PACKET = 2'd1;
    localparam logic [1:0] KIND_CHARGE_ON = 2'd2;
    localparam logic [1:0] KIND_CHARGE_OFF = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CALL_COMMAND = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_SLOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_MID = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_FAST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BREATHE_LOW = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BREATHE_HIGH = 3'd7;

    typedef struct packed {
        logic [LEVEL_W-1:0] call_command;
        logic [LEVEL_W-1:0] band_low_limit;
        logic [LEVEL_W-1:0] band_high_limit;
        logic [TIMER_W-1:0] delay_slow;
        logic [TIMER_W-1:0] delay_mid;
        logic [TIMER_W-1:0] delay_fast;
        logic [LEVEL_W-1:0] breathe_low;
        logic [LEVEL_W-1:0] breathe_high;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               drive_on;
        logic               present;
    } result_t;

    function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] t);
        sat_inc = (t == TIMER_SAT) ? TIMER_SAT : t + 1'b1;
    endfunction

endpackage

// ----- rtl/plf_cfg.sv -----
// ----------------------------------------------------------------------------
// plf_cfg
// Configuration register bank, written through a plain write port.
// ----------------------------------------------------------------------------
module plf_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [plf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [plf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output plf_pkg::cfg_t                  cfg
);
    import plf_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.call_command    <= 8'd1;
            cfg_reg.band_low_limit  <= 8'd40;
            cfg_reg.band_high_limit <= 8'd120;
            cfg_reg.delay_slow      <= 16'd30;
            cfg_reg.delay_mid       <= 16'd10;
            cfg_reg.delay_fast      <= 16'd2;
            cfg_reg.breathe_low     <= 8'd10;
            cfg_reg.breathe_high    <= 8'd200;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CALL_COMMAND:    cfg_reg.call_command    <= cfg_wdata[LEVEL_W-1:0];
                CFG_BAND_LOW_LIMIT:  cfg_reg.band_low_limit  <= cfg_wdata[LEVEL_W-1:0];
                CFG_BAND_HIGH_LIMIT: cfg_reg.band_high_limit <= cfg_wdata[LEVEL_W-1:0];
                CFG_DELAY_SLOW:      cfg_reg.delay_slow      <= cfg_wdata[TIMER_W-1:0];
                CFG_DELAY_MID:       cfg_reg.delay_mid       <= cfg_wdata[TIMER_W-1:0];
                CFG_DELAY_FAST:      cfg_reg.delay_fast      <= cfg_wdata[TIMER_W-1:0];
                CFG_BREATHE_LOW:     cfg_reg.breathe_low     <= cfg_wdata[LEVEL_W-1:0];
                CFG_BREATHE_HIGH:    cfg_reg.breathe_high    <= cfg_wdata[LEVEL_W-1:0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/plf_step.sv -----
// ----------------------------------------------------------------------------
// plf_step
// Fader state registers and the single-pass update for one request.
// ----------------------------------------------------------------------------
module plf_step
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  plf_pkg::cfg_t                cfg,
    input  logic                         accept,
    input  logic [1:0]                   kind,
    input  logic [plf_pkg::LEVEL_W-1:0]  command_id,
    output plf_pkg::result_t             result_next
);
    import plf_pkg::*;

    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [LEVEL_W-1:0] target_reg, target_next;
    logic               drive_reg, drive_next;
    logic               present_reg, present_next;
    logic               seen_reg, seen_next;
    logic               charging_reg, charging_next;
    logic [TIMER_W-1:0] step_timer_reg, step_timer_next;
    logic [TIMER_W-1:0] window_timer_reg, window_timer_next;

    logic [TIMER_W-1:0] step_inc;
    logic [TIMER_W-1:0] window_inc;
    logic [TIMER_W-1:0] band_delay;
    logic               step_ok;

    always_comb
    begin
        step_inc   = sat_inc(step_timer_reg);
        window_inc = sat_inc(window_timer_reg);

        if (level_reg <= cfg.band_low_limit)
            band_delay = cfg.delay_slow;
        else if (level_reg <= cfg.band_high_limit)
            band_delay = cfg.delay_mid;
        else
            band_delay = cfg.delay_fast;
        step_ok = step_inc > band_delay;

        level_next        = level_reg;
        target_next       = target_reg;
        drive_next        = drive_reg;
        present_next      = present_reg;
        seen_next         = seen_reg;
        charging_next     = charging_reg;
        step_timer_next   = step_timer_reg;
        window_timer_next = window_timer_reg;

        case (kind)
            KIND_TICK:
            begin
                step_timer_next   = step_inc;
                window_timer_next = window_inc;
                if (window_inc > DETECT_WINDOW_TICKS)
                begin
                    window_timer_next = '0;
                    if (present_reg && !seen_reg)
                    begin
                        present_next = 1'b0;
                        target_next  = '0;
                    end
                    seen_next = 1'b0;
                end
                if (level_reg != target_next)
                begin
                    if (step_ok)
                        step_timer_next = '0;
                    if (target_next < level_reg)
                    begin
                        if (step_ok)
                            level_next = level_reg - 1'b1;
                        if (level_next == '0)
                            drive_next = 1'b0;
                    end
                    else
                    begin
                        if (level_reg == '0)
                            drive_next = 1'b1;
                        if (step_ok)
                            level_next = level_reg + 1'b1;
                    end
                end
                if (charging_reg)
                begin
                    if (level_next == cfg.breathe_low)
                        target_next = cfg.breathe_high;
                    else if (level_next == cfg.breathe_high)
                        target_next = cfg.breathe_low;
                end
            end
            KIND_PACKET:
            begin
                if (!charging_reg && command_id == cfg.call_command)
                begin
                    seen_next = 1'b1;
                    if (!present_reg)
                    begin
                        present_next = 1'b1;
                        target_next  = LEVEL_MAX;
                    end
                end
            end
            KIND_CHARGE_ON:
            begin
                charging_next = 1'b1;
                target_next   = cfg.breathe_low;
            end
            KIND_CHARGE_OFF:
            begin
                charging_next = 1'b0;
                target_next   = '0;
            end
            default:
            begin
                charging_next = charging_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg        <= LEVEL_MAX;
            target_reg       <= '0;
            drive_reg        <= 1'b1;
            present_reg      <= 1'b0;
            seen_reg         <= 1'b0;
            charging_reg     <= 1'b0;
            step_timer_reg   <= '0;
            window_timer_reg <= '0;
        end
        else if (accept)
        begin
            level_reg        <= level_next;
            target_reg       <= target_next;
            drive_reg        <= drive_next;
            present_reg      <= present_next;
            seen_reg         <= seen_next;
            charging_reg     <= charging_next;
            step_timer_reg   <= step_timer_next;
            window_timer_reg <= window_timer_next;
        end
    end

    assign result_next.level    = level_next;
    assign result_next.drive_on = drive_next;
    assign result_next.present  = present_next;

endmodule

// ----- rtl/plf_out.sv -----
// ----------------------------------------------------------------------------
// plf_out
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module plf_out
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  plf_pkg::result_t  result_in,
    input  logic              m_tready,
    output logic              m_tvalid,
    output plf_pkg::result_t  result_out,
    output logic              can_load
);
    import plf_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign can_load = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (m_tready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result_in;
    end

    assign m_tvalid   = valid_reg;
    assign result_out = data_reg;

endmodule

// ----- rtl/presence_led_fader_unit.sv -----
// ----------------------------------------------------------------------------
// presence_led_fader_unit
// LED level fader driven by presence packets, a detector window and charging.
// ----------------------------------------------------------------------------
// Every request (tick, packet, charge start, charge end) yields one result
// with the LED level, drive enable and presence flag after that request. The
// whole update is one pass of compare and increment logic into the state
// registers, so one request is taken per clock unless the result register
// stalls, and its result shows on the master side in the next cycle. The
// only stall comes from the result register: a new request is taken
// whenever that register is empty or is being read in the same cycle.
module presence_led_fader_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [plf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [plf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] command_id
    input  logic [1:0]                     s_tuser,   // [1:0] kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata    // [7:0] level, [8] drive_on,
                                                      // [9] present, [15:10] zero
);
    import plf_pkg::*;

    cfg_t    cfg;
    result_t result_next;
    result_t result_q;
    logic    accept;
    logic    can_load;

    assign s_tready = can_load;
    assign accept   = s_tvalid && can_load;

    plf_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    plf_step u_step
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .accept      (accept),
        .kind        (s_tuser),
        .command_id  (s_tdata),
        .result_next (result_next)
    );

    plf_out u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .result_in  (result_next),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .result_out (result_q),
        .can_load   (can_load)
    );

    assign m_tdata = {6'd0, result_q.present, result_q.drive_on, result_q.level};

`ifndef SYNTHESIS
    a_accept_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted request left no result");

    a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with result register free");

    a_level_single_step : assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && m_tvalid && m_tready |=>
            (result_q.level == $past(result_q.level)) ||
            (result_q.level == 8'($past(result_q.level) + 8'd1)) ||
            (result_q.level == 8'($past(result_q.level) - 8'd1)))
        else $error("level moved by more than one step");
`endif

endmodule
